[rtl/lst_pkg.sv]
// Shared constants and types for the LCD scan-line and mode timing block.
package lst_pkg;

    localparam int unsigned LINE_CYCLES     = 456;
    localparam int unsigned VISIBLE_LINES   = 144;
    localparam int unsigned LAST_LINE       = 153;
    localparam int unsigned SEARCH_CYCLES   = 82;
    localparam int unsigned TRANSFER_CYCLES = 172;

    localparam int unsigned SEARCH_FLOOR   = LINE_CYCLES - SEARCH_CYCLES;
    localparam int unsigned TRANSFER_FLOOR = LINE_CYCLES - SEARCH_CYCLES - TRANSFER_CYCLES;

    localparam int unsigned CD_W   = 9;
    localparam int unsigned LINE_W = 8;
    localparam int unsigned CYC_W  = 8;
    localparam int unsigned IDX_W  = 2;
    localparam int unsigned DATA_W = 8;

    // register indexes
    localparam logic [IDX_W-1:0] REG_LCD_ON       = 2'd0;
    localparam logic [IDX_W-1:0] REG_COMPARE_LINE = 2'd1;
    localparam logic [IDX_W-1:0] REG_STAT_MASK    = 2'd2;

    // lcd modes
    localparam logic [1:0] MODE_HBLANK   = 2'd0;
    localparam logic [1:0] MODE_VBLANK   = 2'd1;
    localparam logic [1:0] MODE_SEARCH   = 2'd2;
    localparam logic [1:0] MODE_TRANSFER = 2'd3;

    // bits of the STAT enable mask
    localparam int unsigned EN_HBLANK = 0;
    localparam int unsigned EN_VBLANK = 1;
    localparam int unsigned EN_SEARCH = 2;
    localparam int unsigned EN_COIN   = 3;

    typedef struct packed {
        logic              lcd_on;
        logic [LINE_W-1:0] compare_line;
        logic [3:0]        stat_enable_mask;
    } cfg_t;

    typedef struct packed {
        logic [LINE_W-1:0] scan_line;
        logic [CD_W-1:0]   line_countdown;
        logic              prev_status;
    } state_t;

    typedef struct packed {
        logic [LINE_W-1:0] current_line;
        logic [1:0]        lcd_mode;
        logic              coincidence;
        logic              vblank_irq;
        logic              stat_irq;
        logic              draw_request;
        logic [LINE_W-1:0] draw_line_number;
    } result_t;

endpackage

[rtl/lst_if.sv]
// Handshake channel interfaces: tick input, result output and register writes.
interface lst_in_if
    import lst_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic [CYC_W-1:0] elapsed_cycles;

    modport source (output valid, output elapsed_cycles, input ready);
    modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

interface lst_out_if
    import lst_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [LINE_W-1:0] current_line;
    logic [1:0]        lcd_mode;
    logic              coincidence;
    logic              vblank_irq;
    logic              stat_irq;
    logic              draw_request;
    logic [LINE_W-1:0] draw_line_number;

    modport source (output valid, output current_line, output lcd_mode,
                    output coincidence, output vblank_irq, output stat_irq,
                    output draw_request, output draw_line_number, input ready);
    modport sink   (input valid, input current_line, input lcd_mode,
                    input coincidence, input vblank_irq, input stat_irq,
                    input draw_request, input draw_line_number, output ready);
endinterface

interface lst_cfg_if
    import lst_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/lst_cfg_regs.sv]
// Configuration register file: display enable, compare line, STAT enables.
module lst_cfg_regs
    import lst_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    lst_cfg_if.sink cfg,
    output cfg_t  cfg_q
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_LCD_ON:       cfg_next.lcd_on           = cfg.data[0];
                REG_COMPARE_LINE: cfg_next.compare_line     = cfg.data[LINE_W-1:0];
                REG_STAT_MASK:    cfg_next.stat_enable_mask = cfg.data[3:0];
                default:          cfg_next = cfg_reg;   // unknown index dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

[rtl/lst_step.sv]
// One-tick update of the line countdown, line counter, mode and interrupts.
module lst_step
    import lst_pkg::*;
(
    input  cfg_t             cfg,
    input  state_t           cur,
    input  logic [CYC_W-1:0] elapsed_cycles,
    output state_t           nxt,
    output result_t          res
);

    localparam logic [CD_W-1:0]   CD_RELOAD  = CD_W'(LINE_CYCLES);
    localparam logic [CD_W-1:0]   CD_SEARCH  = CD_W'(SEARCH_FLOOR);
    localparam logic [CD_W-1:0]   CD_XFER    = CD_W'(TRANSFER_FLOOR);
    localparam logic [LINE_W-1:0] LN_VISIBLE = LINE_W'(VISIBLE_LINES);
    localparam logic [LINE_W-1:0] LN_LAST    = LINE_W'(LAST_LINE);

    logic signed [CD_W:0] diff;
    logic                 line_end;
    logic [LINE_W-1:0]    line_inc;
    logic [LINE_W-1:0]    line_new;
    logic [CD_W-1:0]      cd_new;
    logic [1:0]           mode;
    logic                 coin;
    logic                 cond;

    always_comb
    begin
        diff     = $signed({1'b0, cur.line_countdown}) - $signed({2'b00, elapsed_cycles});
        line_end = diff[CD_W] || (diff == '0);
        cd_new   = line_end ? CD_RELOAD : diff[CD_W-1:0];
        line_inc = cur.scan_line + LINE_W'(1);
        line_new = cur.scan_line;
        if (line_end)
            line_new = (line_inc > LN_LAST) ? '0 : line_inc;

        if (line_new >= LN_VISIBLE)
            mode = MODE_VBLANK;
        else if (cd_new >= CD_SEARCH)
            mode = MODE_SEARCH;
        else if (cd_new >= CD_XFER)
            mode = MODE_TRANSFER;
        else
            mode = MODE_HBLANK;

        coin = (line_new == cfg.compare_line);
        cond = (coin && cfg.stat_enable_mask[EN_COIN])
            || (mode == MODE_SEARCH && cfg.stat_enable_mask[EN_SEARCH])
            || (mode == MODE_VBLANK && cfg.stat_enable_mask[EN_VBLANK])
            || (mode == MODE_HBLANK && cfg.stat_enable_mask[EN_HBLANK]);

        if (cfg.lcd_on)
        begin
            nxt.scan_line          = line_new;
            nxt.line_countdown     = cd_new;
            nxt.prev_status        = cond;
            res.current_line       = line_new;
            res.lcd_mode           = mode;
            res.coincidence        = coin;
            res.vblank_irq         = line_end && (line_inc == LN_VISIBLE);
            res.stat_irq           = cond && !cur.prev_status;
            res.draw_request       = line_end && (cur.scan_line < LN_VISIBLE);
            res.draw_line_number   = res.draw_request ? cur.scan_line : '0;
        end
        else
        begin
            // display off: everything held at reset, reports vblank mode
            nxt.scan_line          = '0;
            nxt.line_countdown     = CD_RELOAD;
            nxt.prev_status        = 1'b0;
            res                    = '0;
            res.lcd_mode           = MODE_VBLANK;
        end
    end

endmodule

[rtl/lcd_scanline_mode_timing_core.sv]
// Top level of the LCD scan-line and mode timing block.
// Takes one tick per clock while results are taken. A tick is held in an
// input register; the update (subtract from the line countdown, line advance,
// mode, coincidence and interrupt edge) is combinational from that register
// and lands in the result register once that register is free or being taken.
// A stalled result holds in its register, and one further tick waits in the
// input register. Registers are to be written through cfg only while no tick
// is in flight; the block does not enforce this. cfg is always ready.
module lcd_scanline_mode_timing_core
    import lst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    lst_in_if.sink    tick,
    lst_out_if.source result,
    lst_cfg_if.sink   cfg
);

    cfg_t             cfg_q;
    state_t           state_reg;
    state_t           state_next;
    result_t          res_next;
    result_t          res_reg;
    logic             res_valid_reg;
    logic             in_valid_reg;
    logic [CYC_W-1:0] elapsed_reg;
    logic             advance;
    logic             fire;

    lst_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    lst_step u_step (
        .cfg            (cfg_q),
        .cur            (state_reg),
        .elapsed_cycles (elapsed_reg),
        .nxt            (state_next),
        .res            (res_next)
    );

    assign advance    = !res_valid_reg || result.ready;
    assign fire       = in_valid_reg && advance;
    assign tick.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg.scan_line      <= '0;
            state_reg.line_countdown <= CD_W'(LINE_CYCLES);
            state_reg.prev_status    <= 1'b0;
        end
        else
        begin
            if (tick.ready)
                in_valid_reg <= tick.valid;
            if (advance)
                res_valid_reg <= in_valid_reg;
            if (fire)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
            elapsed_reg <= tick.elapsed_cycles;
        if (fire)
            res_reg <= res_next;
    end

    assign result.valid            = res_valid_reg;
    assign result.current_line     = res_reg.current_line;
    assign result.lcd_mode         = res_reg.lcd_mode;
    assign result.coincidence      = res_reg.coincidence;
    assign result.vblank_irq       = res_reg.vblank_irq;
    assign result.stat_irq         = res_reg.stat_irq;
    assign result.draw_request     = res_reg.draw_request;
    assign result.draw_line_number = res_reg.draw_line_number;

endmodule
